// ===== rtl/erle_pkg.sv =====
package erle_pkg;

  localparam logic [7:0] ESC_RESET   = 8'd36;
  localparam logic [3:0] LIMIT_RESET = 4'd9;
  localparam logic [3:0] DIGIT_MAX   = 4'd9;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;

  typedef enum logic [0:0] {
    CFG_ESCAPE = 1'b0,
    CFG_LIMIT  = 1'b1
  } cfg_idx_t;

  // One queued transaction group: up to three output bytes for one input item.
  typedef struct packed {
    logic [2:0][7:0] byt;
    logic [1:0]      num;   // bytes used, 1..3
    logic            done;  // item closed the stream
  } cmd_t;

  function automatic logic [7:0] count_digit(logic [3:0] c);
    return ASCII_ZERO + {4'b0000, c};
  endfunction

endpackage

// ===== rtl/erle_in_if.sv =====
interface erle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/erle_out_if.sv =====
interface erle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       stream_done;

  modport source (output valid, output out_byte, output out_last, output stream_done,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input stream_done,
                  output ready);
endinterface

// ===== rtl/escaped_run_length_encoder_top.sv =====
// Escaped run-length encoder.
// An item's first output byte passes through the queue and then the output register.
// Throughput: one input item per cycle while the queue has room; output side
// moves one byte per cycle while out_ch.ready is high; an item yields 0 to 3 bytes.
// Reset (rst, synchronous, active high): no stream in progress, queue empty,
// escape_code = 0x24, run_limit = 9.
module escaped_run_length_encoder_top import erle_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  erle_in_if.sink    in_ch,
  erle_out_if.source out_ch
);

  // Front: holds stream state and config, turns each input transaction into
  // a group of 0..3 output bytes. Groups with no bytes are dropped here.
  logic q_full;
  logic push;
  cmd_t push_cmd;

  // Back side of the queue
  logic head_valid;
  cmd_t head;
  logic pop;

  erle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_idx_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Short queue decouples input acceptance from the byte-serial output.
  erle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: walks each group one byte per transaction into the output register,
  // tagging the final byte with out_last and, if the item ended the stream,
  // stream_done.
  erle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== rtl/erle_front.sv =====
module erle_front import erle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  cfg_idx_t   cfg_index,
  input  logic [7:0] cfg_data,
  erle_in_if.sink    in_ch,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [7:0] escape_code;
  logic [3:0] run_limit;
  logic       started;
  logic [7:0] prior_byte;
  logic [3:0] repeat_count;

  logic       started_next;
  logic [7:0] prior_byte_next;
  logic [3:0] repeat_count_next;

  logic [3:0] limit;
  logic [3:0] cnt_inc;
  logic       ends;
  logic       accept;
  logic [7:0] b;
  cmd_t       cmd;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.in_byte;

  always_comb begin
    limit   = (run_limit > DIGIT_MAX) ? DIGIT_MAX : run_limit;
    ends    = in_ch.in_last || (b == escape_code);
    cnt_inc = repeat_count + 4'd1;
    cmd      = '0;
    cmd.done = ends;
    started_next      = !ends;
    prior_byte_next   = prior_byte;
    repeat_count_next = 4'd0;
    if (!started) begin
      cmd.byt[0]      = b;
      cmd.num         = 2'd1;
      prior_byte_next = b;
    end else if (b == prior_byte && repeat_count < limit) begin
      // repeat: only counted, flushed if the stream ends here
      repeat_count_next = ends ? 4'd0 : cnt_inc;
      if (ends) begin
        if (cnt_inc == 4'd1) begin
          cmd.byt[0] = prior_byte;
          cmd.num    = 2'd1;
        end else begin
          cmd.byt[0] = escape_code;
          cmd.byt[1] = count_digit(cnt_inc);
          cmd.num    = 2'd2;
        end
      end
    end else begin
      prior_byte_next = b;
      if (repeat_count == 4'd0) begin
        cmd.byt[0] = b;
        cmd.num    = 2'd1;
      end else if (repeat_count == 4'd1) begin
        cmd.byt[0] = prior_byte;
        cmd.byt[1] = b;
        cmd.num    = 2'd2;
      end else begin
        cmd.byt[0] = escape_code;
        cmd.byt[1] = count_digit(repeat_count);
        cmd.byt[2] = b;
        cmd.num    = 2'd3;
      end
    end
  end

  assign push     = accept && (cmd.num != 2'd0);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_code  <= ESC_RESET;
      run_limit    <= LIMIT_RESET;
      started      <= 1'b0;
      prior_byte   <= 8'd0;
      repeat_count <= 4'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ESCAPE: escape_code <= cfg_data;
          CFG_LIMIT:  run_limit   <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (accept) begin
        started      <= started_next;
        prior_byte   <= prior_byte_next;
        repeat_count <= repeat_count_next;
      end
    end
  end

  a_count_fits_digit: assert property (@(posedge clk) disable iff (rst)
    repeat_count <= DIGIT_MAX)
    else $error("repeat count above one digit");

  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    !started |-> repeat_count == 4'd0)
    else $error("count held with no stream in progress");

endmodule

// ===== rtl/erle_fifo.sv =====
module erle_fifo import erle_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ===== rtl/erle_back.sv =====
module erle_back import erle_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  cmd_t      head,
  output logic      pop,
  erle_out_if.source out_ch
);

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       stream_done;
  logic [1:0] idx;
  logic       head_last;
  logic       load;

  assign head_last = (idx == head.num - 2'd1);
  assign load      = head_valid && (!out_valid || out_ch.ready);
  assign pop       = load && head_last;

  assign out_ch.valid       = out_valid;
  assign out_ch.out_byte    = out_byte;
  assign out_ch.out_last    = out_last;
  assign out_ch.stream_done = stream_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= head_last ? 2'd0 : idx + 2'd1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= head.byt[idx];
      out_last    <= head_last;
      stream_done <= head_last && head.done;
    end
  end

  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx < head.num)
    else $error("byte index past end of group");

endmodule
